// ----- design/text_console_cursor_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// Text console cursor engine assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, constants and helpers shared by the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  // configuration field widths
  localparam int unsigned ColsW   = 9;
  localparam int unsigned RowsW   = 8;
  localparam int unsigned LineW   = 14;
  localparam int unsigned CellWW  = 6;
  localparam int unsigned CellHW  = 6;
  localparam int unsigned GlyphCW = 10;
  localparam int unsigned TabW    = 5;

  // cursor and result widths
  localparam int unsigned CurColW = 8;
  localparam int unsigned CurRowW = 7;
  localparam int unsigned GlyphW  = 9;
  localparam int unsigned OffW    = 25;
  localparam int unsigned CntW    = 5;

  // shared multiplier operand widths
  localparam int unsigned MulAW = 13;
  localparam int unsigned MulBW = 14;

  // APB port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [CntW-1:0] MaxRun = 5'd16;

  // character codes
  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;

  // event kinds
  localparam logic EvCell   = 1'b0;
  localparam logic EvScroll = 1'b1;

  typedef enum logic [2:0] {
    REG_COLUMNS     = 3'd0,
    REG_ROWS        = 3'd1,
    REG_LINE_PIXELS = 3'd2,
    REG_CELL_WIDTH  = 3'd3,
    REG_CELL_HEIGHT = 3'd4,
    REG_GLYPH_COUNT = 3'd5,
    REG_TAB_SIZE    = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROWMUL,
    ST_LPMUL,
    ST_COLMUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [ColsW-1:0]   columns;
    logic [RowsW-1:0]   rows;
    logic [LineW-1:0]   line_pixels;
    logic [CellWW-1:0]  cell_width;
    logic [CellHW-1:0]  cell_height;
    logic [GlyphCW-1:0] glyph_count;
    logic [TabW-1:0]    tab_size;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    columns:     9'd80,
    rows:        8'd25,
    line_pixels: 14'd1024,
    cell_width:  6'd8,
    cell_height: 6'd16,
    glyph_count: 10'd256,
    tab_size:    5'd4
  };

  // zero acts as one, oversized clamps to the grid limit
  function automatic logic [ColsW-1:0] eff_columns(input logic [ColsW-1:0] c);
    logic [ColsW-1:0] r;
    if (c == '0) r = 9'd1;
    else if (c > 9'd256) r = 9'd256;
    else r = c;
    return r;
  endfunction

  function automatic logic [RowsW-1:0] eff_rows(input logic [RowsW-1:0] n);
    logic [RowsW-1:0] r;
    if (n == '0) r = 8'd1;
    else if (n > 8'd128) r = 8'd128;
    else r = n;
    return r;
  endfunction

  function automatic logic [GlyphW-1:0] glyph_of(input logic [7:0] code,
                                                 input logic [GlyphCW-1:0] gc);
    logic [GlyphW-1:0] g;
    if ({2'b00, code} < gc) g = {1'b0, code};
    else g = '0;
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- design/tcce_regs.sv -----
// ----------------------------------------------------------------------------
// tcce_regs
// APB register file holding the console geometry and font settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tcce_pkg::AddrW-1:0] paddr,
  input  wire logic [tcce_pkg::DataW-1:0] pwdata,
  output logic      [tcce_pkg::DataW-1:0] prdata,
  output logic                            pready,
  output tcce_pkg::cfg_t                  cfg_o
);
  import tcce_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_COLUMNS:     cfg_d.columns     = pwdata[ColsW-1:0];
        REG_ROWS:        cfg_d.rows        = pwdata[RowsW-1:0];
        REG_LINE_PIXELS: cfg_d.line_pixels = pwdata[LineW-1:0];
        REG_CELL_WIDTH:  cfg_d.cell_width  = pwdata[CellWW-1:0];
        REG_CELL_HEIGHT: cfg_d.cell_height = pwdata[CellHW-1:0];
        REG_GLYPH_COUNT: cfg_d.glyph_count = pwdata[GlyphCW-1:0];
        REG_TAB_SIZE:    cfg_d.tab_size    = pwdata[TabW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COLUMNS:     prdata = DataW'(cfg_q.columns);
      REG_ROWS:        prdata = DataW'(cfg_q.rows);
      REG_LINE_PIXELS: prdata = DataW'(cfg_q.line_pixels);
      REG_CELL_WIDTH:  prdata = DataW'(cfg_q.cell_width);
      REG_CELL_HEIGHT: prdata = DataW'(cfg_q.cell_height);
      REG_GLYPH_COUNT: prdata = DataW'(cfg_q.glyph_count);
      REG_TAB_SIZE:    prdata = DataW'(cfg_q.tab_size);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/tcce_mac.sv -----
// ----------------------------------------------------------------------------
// tcce_mac
// Shared multiply-accumulate unit for the cell offset, wrapping at 25 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_mac (
  input  wire logic [tcce_pkg::MulAW-1:0] a_i,
  input  wire logic [tcce_pkg::MulBW-1:0] b_i,
  input  wire logic [tcce_pkg::OffW-1:0]  acc_i,
  output logic      [tcce_pkg::OffW-1:0]  y_o
);
  import tcce_pkg::*;

  logic [MulAW+MulBW-1:0] prod;

  assign prod = {{MulBW{1'b0}}, a_i} * {{MulAW{1'b0}}, b_i};
  assign y_o  = acc_i + prod[OffW-1:0];

endmodule

`default_nettype wire

// ----- design/text_console_cursor_engine_top.sv -----
// Cell writes: a printable byte's cell write is registered after the row, line and column
//   multiply steps on one shared multiplier; a newline scroll is valid the cycle after acceptance.
// Flow: one character at a time; CR, backspace, plain newline and an empty tab finish in the
//   idle state, while a printable byte (and its scroll when it wraps into one), a scrolling
//   newline or a tab's spaces hold input ready low; each result waits in the output register.
// Reset: async active-low clears cursor, sequencer and output valid; registers take defaults.
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Cursor tracking and cell write / scroll event generation for a text console.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cursor_engine_top_macros.svh"

module text_console_cursor_engine_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // APB configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tcce_pkg::AddrW-1:0] paddr,
  input  wire logic [tcce_pkg::DataW-1:0] pwdata,
  output logic      [tcce_pkg::DataW-1:0] prdata,
  output logic                            pready,
  // character requests
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [7:0]                 char_code_i,
  // result requests
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            event_kind_o,
  output logic [tcce_pkg::CurColW-1:0]    cell_column_o,
  output logic [tcce_pkg::CurRowW-1:0]    cell_row_o,
  output logic [tcce_pkg::GlyphW-1:0]     glyph_index_o,
  output logic [tcce_pkg::OffW-1:0]       pixel_offset_o,
  output logic                            last_of_run_o
);
  import tcce_pkg::*;

  cfg_t cfg;

  tcce_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e               state_q, state_d;
  logic [CurColW-1:0]   col_q, col_d;
  logic [CurRowW-1:0]   row_q, row_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [GlyphW-1:0]    glyph_q, glyph_d;
  logic                 prt_q, prt_d;
  logic                 scr_q, scr_d;
  logic [MulAW-1:0]     prod_q, prod_d;
  logic [OffW-1:0]      base_q, base_d;

  logic                 ov_q, ov_d;
  logic                 kind_q, kind_d;
  logic [CurColW-1:0]   ocol_q, ocol_d;
  logic [CurRowW-1:0]   orow_q, orow_d;
  logic [GlyphW-1:0]    oglyph_q, oglyph_d;
  logic [OffW-1:0]      ooff_q, ooff_d;
  logic                 olast_q, olast_d;

  logic [ColsW-1:0]     nc, col_inc, left, tab9;
  logic [RowsW-1:0]     nr, row_inc, nr_last;
  logic                 wrap, row_over;
  logic [CntW-1:0]      tab_cnt;
  logic                 in_acc;

  logic [MulAW-1:0]     mac_a;
  logic [MulBW-1:0]     mac_b;
  logic [OffW-1:0]      mac_acc, mac_y;

  tcce_mac u_mac (
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_i (mac_acc),
    .y_o   (mac_y)
  );

  assign nc       = eff_columns(cfg.columns);
  assign nr       = eff_rows(cfg.rows);
  assign nr_last  = nr - 8'd1;
  assign col_inc  = {1'b0, col_q} + 9'd1;
  assign row_inc  = {1'b0, row_q} + 8'd1;
  assign wrap     = (col_inc >= nc);
  assign row_over = (row_inc >= nr);

  // spaces for a tab: room left on the line, bounded by tab_size and the run cap
  always_comb begin
    left = nc - col_inc;
    tab9 = (left < {4'b0, cfg.tab_size}) ? left : {4'b0, cfg.tab_size};
    if (wrap) tab_cnt = '0;
    else if (tab9 > {4'b0, MaxRun}) tab_cnt = MaxRun;
    else tab_cnt = tab9[CntW-1:0];
  end

  // operand select for the shared multiplier
  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_acc = '0;
    unique case (state_q)
      ST_ROWMUL: begin
        mac_a = MulAW'(row_q);
        mac_b = MulBW'(cfg.cell_height);
      end
      ST_LPMUL: begin
        mac_a = prod_q;
        mac_b = cfg.line_pixels;
      end
      ST_COLMUL: begin
        mac_a   = MulAW'(col_q);
        mac_b   = MulBW'(cfg.cell_width);
        mac_acc = base_q;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    cnt_d    = cnt_q;
    glyph_d  = glyph_q;
    prt_d    = prt_q;
    scr_d    = scr_q;
    prod_d   = prod_q;
    base_d   = base_q;
    ov_d     = ov_q & ~out_ready_i;
    kind_d   = kind_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    oglyph_d = oglyph_q;
    ooff_d   = ooff_q;
    olast_d  = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (char_code_i)
            ChCr: col_d = '0;
            ChBs: begin
              if (col_q != '0) col_d = col_q - 8'd1;
            end
            ChLf: begin
              col_d = '0;
              if (row_over) begin
                row_d    = nr_last[CurRowW-1:0];
                ov_d     = 1'b1;
                kind_d   = EvScroll;
                ocol_d   = '0;
                orow_d   = '0;
                oglyph_d = '0;
                ooff_d   = '0;
                olast_d  = 1'b1;
                state_d  = ST_OUT;
              end else begin
                row_d = row_inc[CurRowW-1:0];
              end
            end
            ChTab: begin
              if (tab_cnt != '0) begin
                cnt_d   = tab_cnt;
                glyph_d = glyph_of(ChSpace, cfg.glyph_count);
                prt_d   = 1'b0;
                state_d = ST_ROWMUL;
              end
            end
            default: begin
              cnt_d   = 5'd1;
              glyph_d = glyph_of(char_code_i, cfg.glyph_count);
              prt_d   = 1'b1;
              state_d = ST_ROWMUL;
            end
          endcase
        end
      end
      ST_ROWMUL: begin
        prod_d  = mac_y[MulAW-1:0];
        state_d = ST_LPMUL;
      end
      ST_LPMUL: begin
        base_d  = mac_y;
        state_d = ST_COLMUL;
      end
      ST_COLMUL: begin
        ov_d     = 1'b1;
        kind_d   = EvCell;
        ocol_d   = col_q;
        orow_d   = row_q;
        oglyph_d = glyph_q;
        ooff_d   = mac_y;
        // a printable byte ends its run unless a scroll follows
        olast_d  = prt_q ? !(wrap && row_over) : (cnt_q == 5'd1);
        cnt_d    = cnt_q - 5'd1;
        if (prt_q && wrap) begin
          col_d = '0;
          if (row_over) begin
            row_d = nr_last[CurRowW-1:0];
            scr_d = 1'b1;
          end else begin
            row_d = row_inc[CurRowW-1:0];
          end
        end else begin
          col_d = col_inc[CurColW-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (scr_q) begin
            scr_d    = 1'b0;
            ov_d     = 1'b1;
            kind_d   = EvScroll;
            ocol_d   = '0;
            orow_d   = '0;
            oglyph_d = '0;
            ooff_d   = '0;
            olast_d  = 1'b1;
          end else if (cnt_q != '0) begin
            state_d = ST_COLMUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      prt_q   <= 1'b0;
      scr_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      prt_q   <= prt_d;
      scr_q   <= scr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q  <= glyph_d;
    prod_q   <= prod_d;
    base_q   <= base_d;
    kind_q   <= kind_d;
    ocol_q   <= ocol_d;
    orow_q   <= orow_d;
    oglyph_q <= oglyph_d;
    ooff_q   <= ooff_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o    = ov_q;
  assign event_kind_o   = kind_q;
  assign cell_column_o  = ocol_q;
  assign cell_row_o     = orow_q;
  assign glyph_index_o  = oglyph_q;
  assign pixel_offset_o = ooff_q;
  assign last_of_run_o  = olast_q;

  `TCCE_ASSERT_IMP(a_ready_no_pending, in_ready_o, !out_valid_o, "input ready with result pending")
  `TCCE_ASSERT_IMP(a_colmul_has_work, state_q == ST_COLMUL, cnt_q != '0, "column step with empty run")
  `TCCE_ASSERT_IMP(a_scroll_fields, out_valid_o && (event_kind_o == EvScroll), last_of_run_o && (cell_column_o == '0) && (cell_row_o == '0), "scroll result malformed")
  `TCCE_ASSERT_NXT(a_last_to_idle, out_valid_o && out_ready_i && last_of_run_o, (state_q == ST_IDLE) && !out_valid_o, "run did not end after last result")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console cursor engine: a directed table
// then randomized register phases and character streams, with random gaps on
// the request side and stalls on the result side, checked in order against a
// cycle-free cursor tracker.
// ----------------------------------------------------------------------------

module tb;
  import tcce_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxShown   = 10;

  typedef struct packed {
    logic               kind;
    logic [CurColW-1:0] col;
    logic [CurRowW-1:0] row;
    logic [GlyphW-1:0]  glyph;
    logic [OffW-1:0]    off;
    logic               last;
  } console_event_t;

  typedef enum logic {STEP_CHAR, STEP_CFG} step_kind_e;

  typedef struct {
    step_kind_e     kind;
    logic [7:0]     code;
    reg_idx_e       idx;
    logic [31:0]    val;
    bit             typed;
    bit             has_ev;
    console_event_t ev;
  } step_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         char_code_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               event_kind_o;
  logic [CurColW-1:0] cell_column_o;
  logic [CurRowW-1:0] cell_row_o;
  logic [GlyphW-1:0]  glyph_index_o;
  logic [OffW-1:0]    pixel_offset_o;
  logic               last_of_run_o;

  text_console_cursor_engine_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .cell_column_o  (cell_column_o),
    .cell_row_o     (cell_row_o),
    .glyph_index_o  (glyph_index_o),
    .pixel_offset_o (pixel_offset_o),
    .last_of_run_o  (last_of_run_o)
  );

  // tracker state: register shadow and cursor
  cfg_t           shadow_cfg = CfgReset;
  int unsigned    cur_col = 0;
  int unsigned    cur_row = 0;
  console_event_t char_events[$];
  console_event_t events_due[$];

  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          gap_on = 1'b1;
  bit          stall_on = 1'b1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 99) < 20) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic string ev_str(input console_event_t e);
    return $sformatf("kind %0d col %0d row %0d glyph %0d off %0d last %0d",
                     e.kind, e.col, e.row, e.glyph, e.off, e.last);
  endfunction

  function automatic void report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MaxShown) $display("tb: %s", msg);
  endfunction

  function automatic int unsigned grid_cols();
    if (shadow_cfg.columns == '0) return 1;
    if (shadow_cfg.columns > 9'd256) return 256;
    return int'(shadow_cfg.columns);
  endfunction

  function automatic int unsigned grid_rows();
    if (shadow_cfg.rows == '0) return 1;
    if (shadow_cfg.rows > 8'd128) return 128;
    return int'(shadow_cfg.rows);
  endfunction

  function automatic void line_feed();
    console_event_t ev;
    ev = '0;
    ev.kind = EvScroll;
    cur_col = 0;
    cur_row++;
    if (cur_row >= grid_rows()) begin
      char_events.push_back(ev);
      cur_row = grid_rows() - 1;
    end
  endfunction

  function automatic void put_cell(input logic [7:0] code);
    console_event_t    ev;
    longint unsigned   off;
    ev = '0;
    ev.kind = EvCell;
    ev.col = cur_col[CurColW-1:0];
    ev.row = cur_row[CurRowW-1:0];
    ev.glyph = ({2'b00, code} < shadow_cfg.glyph_count) ? {1'b0, code} : '0;
    off = 64'(cur_row) * 64'(shadow_cfg.cell_height) * 64'(shadow_cfg.line_pixels)
        + 64'(cur_col) * 64'(shadow_cfg.cell_width);
    ev.off = off[OffW-1:0];
    char_events.push_back(ev);
    cur_col++;
    // a cursor left outside a shrunken grid still wraps here
    if (cur_col >= grid_cols()) line_feed();
  endfunction

  function automatic void track_char(input logic [7:0] code);
    int unsigned left;
    int unsigned cnt;
    char_events.delete();
    case (code)
      ChCr: cur_col = 0;
      ChBs: if (cur_col > 0) cur_col--;
      ChTab: begin
        cnt = 0;
        if (cur_col + 1 < grid_cols()) begin
          left = grid_cols() - cur_col - 1;
          cnt = (left > shadow_cfg.tab_size) ? shadow_cfg.tab_size : left;
        end
        if (cnt > MaxRun) cnt = MaxRun;
        repeat (cnt) put_cell(ChSpace);
      end
      ChLf: line_feed();
      default: put_cell(code);
    endcase
    if (char_events.size() > 0) char_events[char_events.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin : result_check
    console_event_t got;
    console_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{event_kind_o, cell_column_o, cell_row_o, glyph_index_o,
              pixel_offset_o, last_of_run_o};
      if (events_due.size() == 0) begin
        report_fail({"unexpected result: ", ev_str(got)});
      end else begin
        want = events_due.pop_front();
        if (got !== want)
          report_fail({"mismatch\n  expected ", ev_str(want), "\n  actual   ", ev_str(got)});
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_COLUMNS:     shadow_cfg.columns     = val[ColsW-1:0];
      REG_ROWS:        shadow_cfg.rows        = val[RowsW-1:0];
      REG_LINE_PIXELS: shadow_cfg.line_pixels = val[LineW-1:0];
      REG_CELL_WIDTH:  shadow_cfg.cell_width  = val[CellWW-1:0];
      REG_CELL_HEIGHT: shadow_cfg.cell_height = val[CellHW-1:0];
      REG_GLYPH_COUNT: shadow_cfg.glyph_count = val[GlyphCW-1:0];
      REG_TAB_SIZE:    shadow_cfg.tab_size    = val[TabW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_char(input logic [7:0] code, input bit typed, input bit has_ev,
                           input console_event_t ev);
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_char(code);
    if (!typed) begin
      foreach (char_events[k]) events_due.push_back(char_events[k]);
    end else if (has_ev) begin
      events_due.push_back(ev);
    end
  endtask

  task automatic maybe_gap();
    if (gap_on && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // hold off until every result is out, plus room for CR/backspace work
  task automatic settle();
    in_valid_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_cfg(input reg_idx_e idx);
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 5);
    v = '0;
    case (idx)
      REG_COLUMNS: case (r)
        0: v = 0;
        1: v = 1;
        2: v = 256;
        3: v = $urandom_range(257, 511);
        default: v = $urandom_range(2, 100);
      endcase
      REG_ROWS: case (r)
        0: v = 0;
        1: v = 1;
        2: v = 128;
        3: v = $urandom_range(129, 255);
        default: v = $urandom_range(2, 40);
      endcase
      REG_LINE_PIXELS: case (r)
        0: v = 1;
        1: v = 16383;
        2: v = 0;
        default: v = $urandom_range(1, 2048);
      endcase
      REG_CELL_WIDTH: case (r)
        0: v = 8;
        1: v = 16;
        2: v = 32;
        3: v = $urandom_range(0, 1) ? 63 : 0;
        4: v = $urandom_range(0, 63);
        default: v = 24;
      endcase
      REG_CELL_HEIGHT: case (r)
        0: v = 1;
        1: v = 32;
        2: v = 63;
        3: v = 0;
        default: v = $urandom_range(1, 32);
      endcase
      REG_GLYPH_COUNT: case (r)
        0: v = 0;
        1: v = 1023;
        2: v = 32;
        3: v = 33;
        default: v = $urandom_range(0, 512);
      endcase
      REG_TAB_SIZE: case (r)
        0: v = 0;
        1: v = 16;
        2: v = 31;
        default: v = $urandom_range(1, 16);
      endcase
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_char(input int unsigned ctrl_pct);
    int unsigned r;
    if ($urandom_range(0, 99) >= ctrl_pct) return 8'($urandom_range(0, 255));
    r = $urandom_range(0, 3);
    case (r)
      0: return ChLf;
      1: return ChCr;
      2: return ChBs;
      default: return ChTab;
    endcase
  endfunction

  function automatic step_t char_step(input logic [7:0] code);
    step_t s;
    s.kind   = STEP_CHAR;
    s.code   = code;
    s.idx    = REG_COLUMNS;
    s.val    = '0;
    s.typed  = 1'b0;
    s.has_ev = 1'b0;
    s.ev     = '0;
    return s;
  endfunction

  function automatic step_t quiet_step(input logic [7:0] code);
    step_t s;
    s = char_step(code);
    s.typed = 1'b1;
    return s;
  endfunction

  function automatic step_t cell_step(input logic [7:0] code, input int unsigned col,
                                      input int unsigned row, input int unsigned glyph,
                                      input int unsigned off);
    step_t s;
    s = quiet_step(code);
    s.has_ev   = 1'b1;
    s.ev.kind  = EvCell;
    s.ev.col   = col[CurColW-1:0];
    s.ev.row   = row[CurRowW-1:0];
    s.ev.glyph = glyph[GlyphW-1:0];
    s.ev.off   = off[OffW-1:0];
    s.ev.last  = 1'b1;
    return s;
  endfunction

  function automatic step_t cfg_step(input reg_idx_e idx, input logic [31:0] val);
    step_t s;
    s = char_step('0);
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.val  = val;
    return s;
  endfunction

  initial begin
    step_t       dir_steps[$];
    int unsigned n_items;
    int unsigned ctrl_pct;
    logic [31:0] v;

    // reset defaults: 80x25, 1024 px lines, 8x16 cells, 256 glyphs, tab 4
    dir_steps.push_back(cell_step(8'd65, 0, 0, 65, 0));
    dir_steps.push_back(cell_step(8'd255, 1, 0, 255, 8));
    dir_steps.push_back(cell_step(8'd0, 2, 0, 0, 16));
    dir_steps.push_back(quiet_step(ChBs));
    dir_steps.push_back(quiet_step(ChCr));
    dir_steps.push_back(quiet_step(ChBs));
    dir_steps.push_back(char_step(ChTab));
    dir_steps.push_back(quiet_step(ChLf));
    dir_steps.push_back(cell_step(8'd122, 0, 1, 122, 16384));
    dir_steps.push_back(char_step(8'd128));
    // longest tab run
    dir_steps.push_back(cfg_step(REG_TAB_SIZE, 16));
    dir_steps.push_back(char_step(ChTab));
    // shrink the grid under the cursor
    dir_steps.push_back(cfg_step(REG_COLUMNS, 10));
    dir_steps.push_back(char_step(ChTab));
    dir_steps.push_back(char_step(8'd81));
    dir_steps.push_back(cfg_step(REG_ROWS, 1));
    dir_steps.push_back(char_step(ChLf));
    dir_steps.push_back(cfg_step(REG_GLYPH_COUNT, 0));
    dir_steps.push_back(char_step(8'd65));
    dir_steps.push_back(cfg_step(REG_COLUMNS, 0));
    dir_steps.push_back(char_step(8'd66));
    dir_steps.push_back(cfg_step(REG_TAB_SIZE, 0));
    dir_steps.push_back(char_step(ChTab));
    // everything at the top of its field
    dir_steps.push_back(cfg_step(REG_COLUMNS, 511));
    dir_steps.push_back(cfg_step(REG_ROWS, 255));
    dir_steps.push_back(cfg_step(REG_LINE_PIXELS, 16383));
    dir_steps.push_back(cfg_step(REG_CELL_WIDTH, 63));
    dir_steps.push_back(cfg_step(REG_CELL_HEIGHT, 63));
    dir_steps.push_back(cfg_step(REG_GLYPH_COUNT, 1023));
    dir_steps.push_back(cfg_step(REG_TAB_SIZE, 31));
    dir_steps.push_back(char_step(ChLf));
    dir_steps.push_back(char_step(8'd255));
    dir_steps.push_back(char_step(ChTab));
    dir_steps.push_back(char_step(8'd127));
    dir_steps.push_back(char_step(ChCr));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_CFG) begin
        settle();
        write_reg(dir_steps[i].idx, dir_steps[i].val);
      end else begin
        send_char(dir_steps[i].code, dir_steps[i].typed, dir_steps[i].has_ev,
                  dir_steps[i].ev);
        maybe_gap();
      end
    end

    // phase 1 is a tall one-column screen with big cells to push offsets past 25 bits;
    // phases 2 and 4 run with no gaps or stalls
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      for (int r = REG_COLUMNS; r <= REG_TAB_SIZE; r++) begin
        v = pick_cfg(reg_idx_e'(r));
        if (ph == 1) begin
          case (reg_idx_e'(r))
            REG_COLUMNS:     v = 1;
            REG_ROWS:        v = 128;
            REG_LINE_PIXELS: v = 16383;
            REG_CELL_WIDTH:  v = 63;
            REG_CELL_HEIGHT: v = 63;
            default: ;
          endcase
        end
        write_reg(reg_idx_e'(r), v);
      end
      gap_on   = (ph != 2) && (ph != 4);
      stall_on = gap_on;
      n_items  = (ph == 1) ? 25 : (ph == 4) ? 25 : 12;
      ctrl_pct = (ph == 1) ? 10 : 40;
      repeat (n_items) begin
        send_char(pick_char(ctrl_pct), 1'b0, 1'b0, '0);
        maybe_gap();
      end
    end

    in_valid_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/tcce_pkg.sv
design/tcce_regs.sv
design/tcce_mac.sv
design/text_console_cursor_engine_top.sv
tb/tb.sv
